[src/gcas_pkg.sv]
`default_nettype none
package gcas_pkg;

   localparam int QB       = 30;
   localparam int STEPS    = 30;
   localparam int SQ_STEPS = 32;
   localparam int MAG_W    = 50;
   localparam int ANG_W    = 33;
   localparam int TRIG_W   = 33;
   localparam int ZR_W     = 34;
   localparam int DOT_W    = 34;
   localparam int VX_W     = 36;
   localparam int VZ_W     = 34;
   localparam int ROOT_W   = 32;
   localparam int SQIN_W   = 64;
   localparam int PROD_W   = 2 * TRIG_W;

   // Q30 constants
   localparam logic signed [35:0] PI_Q       = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q  = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q   = 36'sd6746518852;
   localparam logic signed [35:0] INV_GAIN_Q = 36'sd652032874;

   // floor(2^56 / TWO_PI_Q), i.e. 2^26 / 2pi, for the modulo estimate
   localparam logic [23:0] RECIP = 24'((64'd1 << 56) / 64'd6746518852);

   typedef logic signed [MAG_W:0]    wide_ang_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ZR_W-1:0]   zr_type;
   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [VX_W-1:0]   vx_type;
   typedef logic signed [VZ_W-1:0]   vz_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         5'd24: v = 30'h0000003F;
         5'd25: v = 30'h0000001F;
         5'd26: v = 30'h0000000F;
         5'd27: v = 30'h00000007;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   // Q30 product, round to nearest with ties up
   function automatic trig_type qmul(input trig_type a, input trig_type b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b);
      p = p + PROD_W'(1 << (QB - 1));
      return trig_type'(p >>> QB);
   endfunction

endpackage
`default_nettype wire

[src/gcas_if.sv]
`default_nettype none
interface gcas_req_if;
   logic              valid;
   logic              ready;
   logic [30:0]       ra_first;
   logic signed [29:0] dec_first;
   logic [30:0]       ra_second;
   logic signed [29:0] dec_second;

   modport source(output valid, ra_first, dec_first, ra_second, dec_second, input ready);
   modport sink(input valid, ra_first, dec_first, ra_second, dec_second, output ready);
endinterface

interface gcas_rsp_if;
   logic        valid;
   logic        ready;
   logic [29:0] separation;

   modport source(output valid, separation, input ready);
   modport sink(input valid, separation, output ready);
endinterface
`default_nettype wire

[src/gcas_wrap.sv]
`default_nettype none
// Reduces an angle modulo 2pi into [-pi, pi] in four stages.
module gcas_wrap (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  gcas_pkg::wide_ang_type  ang_in,
   output logic                    out_valid,
   output gcas_pkg::ang_type       ang_out
);
   localparam int U_LSB  = 24;
   localparam int MUL_W  = gcas_pkg::MAG_W;
   localparam int Q_W    = MUL_W - 32;
   localparam int R_W    = 34;
   localparam int QT_W   = Q_W + R_W;
   localparam int RS_W   = R_W + 2;

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic neg_a_ff, neg_b_ff, neg_c_ff;
   logic [gcas_pkg::MAG_W-1:0] mag_a_in, mag_a_ff, mag_b_ff;
   logic [MUL_W-1:0] prod_b;
   logic [Q_W-1:0]   q_b_in, q_b_ff;
   logic [QT_W-1:0]  qt_c, diff_c;
   logic [R_W-1:0]   r_c_in, r_c_ff, r1_d;
   logic signed [RS_W-1:0] rs_d, rn_d;
   gcas_pkg::ang_type ang_d_in, ang_d_ff;

   always_comb begin
      mag_a_in = ang_in[gcas_pkg::MAG_W] ? gcas_pkg::MAG_W'(-ang_in)
                                         : gcas_pkg::MAG_W'(ang_in);
      // quotient estimate, at most one short of the true one
      prod_b   = MUL_W'(mag_a_ff[gcas_pkg::MAG_W-1:U_LSB]) * MUL_W'(gcas_pkg::RECIP);
      q_b_in   = prod_b[MUL_W-1:32];
      qt_c     = QT_W'(q_b_ff) * QT_W'(gcas_pkg::TWO_PI_Q[R_W-1:0]);
      diff_c   = QT_W'(mag_b_ff) - qt_c;
      r_c_in   = diff_c[R_W-1:0];
      r1_d     = (r_c_ff >= gcas_pkg::TWO_PI_Q[R_W-1:0]) ?
                 r_c_ff - gcas_pkg::TWO_PI_Q[R_W-1:0] : r_c_ff;
      rs_d     = (r1_d > gcas_pkg::PI_Q[R_W-1:0]) ?
                 signed'({2'b00, r1_d}) - gcas_pkg::TWO_PI_Q : signed'({2'b00, r1_d});
      rn_d     = neg_c_ff ? -rs_d : rs_d;
      ang_d_in = gcas_pkg::ang_type'(rn_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff <= ang_in[gcas_pkg::MAG_W];
         mag_a_ff <= mag_a_in;
         neg_b_ff <= neg_a_ff;
         mag_b_ff <= mag_a_ff;
         q_b_ff   <= q_b_in;
         neg_c_ff <= neg_b_ff;
         r_c_ff   <= r_c_in;
         ang_d_ff <= ang_d_in;
      end
   end

   assign out_valid = vd_ff;
   assign ang_out   = ang_d_ff;
endmodule
`default_nettype wire

[src/gcas_sincos.sv]
`default_nettype none
// Rotation CORDIC, one micro-rotation per stage.
module gcas_sincos (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  gcas_pkg::ang_type    ang_in,
   output logic                 out_valid,
   output gcas_pkg::trig_type   sin_out,
   output gcas_pkg::trig_type   cos_out
);
   localparam int N = gcas_pkg::STEPS;

   logic f_valid_ff, f_flip_ff, f_flip_in;
   gcas_pkg::zr_type f_z_ff, f_z_in;

   logic              it_valid_ff [N];
   logic              it_flip_ff  [N];
   gcas_pkg::trig_type x_ff [N];
   gcas_pkg::trig_type y_ff [N];
   gcas_pkg::zr_type   z_ff [N];

   logic o_valid_ff;
   gcas_pkg::trig_type sin_ff, cos_ff;

   // beyond a quarter turn: work at the angle -/+ pi and negate after
   always_comb begin
      if (ang_in > gcas_pkg::HALF_PI_Q) begin
         f_z_in    = gcas_pkg::zr_type'(ang_in - gcas_pkg::PI_Q);
         f_flip_in = 1'b1;
      end else if (ang_in < -gcas_pkg::HALF_PI_Q) begin
         f_z_in    = gcas_pkg::zr_type'(ang_in + gcas_pkg::PI_Q);
         f_flip_in = 1'b1;
      end else begin
         f_z_in    = gcas_pkg::zr_type'(ang_in);
         f_flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_z_ff    <= f_z_in;
         f_flip_ff <= f_flip_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic               v_src, flip_src;
      gcas_pkg::trig_type x_src, y_src, dx, dy, x_in, y_in;
      gcas_pkg::zr_type   z_src, z_in, step;

      if (i == 0) begin : g_first
         assign v_src    = f_valid_ff;
         assign flip_src = f_flip_ff;
         assign x_src    = gcas_pkg::trig_type'(gcas_pkg::INV_GAIN_Q);
         assign y_src    = '0;
         assign z_src    = f_z_ff;
      end else begin : g_next
         assign v_src    = it_valid_ff[i-1];
         assign flip_src = it_flip_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
      end

      assign dx   = y_src >>> i;
      assign dy   = x_src >>> i;
      assign step = gcas_pkg::zr_type'(gcas_pkg::atan_entry(5'(i)));

      always_comb begin
         if (!z_src[gcas_pkg::ZR_W-1]) begin
            x_in = x_src - dx;
            y_in = y_src + dy;
            z_in = z_src - step;
         end else begin
            x_in = x_src + dx;
            y_in = y_src - dy;
            z_in = z_src + step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            it_valid_ff[i] <= 1'b0;
         end else if (en) begin
            it_valid_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            it_flip_ff[i] <= flip_src;
            x_ff[i]       <= x_in;
            y_ff[i]       <= y_in;
            z_ff[i]       <= z_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= it_valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= it_flip_ff[N-1] ? -y_ff[N-1] : y_ff[N-1];
         cos_ff <= it_flip_ff[N-1] ? -x_ff[N-1] : x_ff[N-1];
      end
   end

   assign out_valid = o_valid_ff;
   assign sin_out   = sin_ff;
   assign cos_out   = cos_ff;
endmodule
`default_nettype wire

[src/gcas_sqrt.sv]
`default_nettype none
// Digit-by-digit floor square root, one result bit per stage.
module gcas_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [gcas_pkg::SQIN_W-1:0] sum_in,
   input  gcas_pkg::dot_type           den_in,
   output logic                        out_valid,
   output logic [gcas_pkg::ROOT_W-1:0] root_out,
   output gcas_pkg::dot_type           den_out
);
   localparam int N   = gcas_pkg::SQ_STEPS;
   localparam int W   = gcas_pkg::ROOT_W;
   localparam int SW  = gcas_pkg::SQIN_W;
   localparam int RMW = W + 3;

   logic              v_ff    [N];
   logic [RMW-1:0]    rem_ff  [N];
   logic [W-1:0]      root_ff [N];
   logic [SW-1:0]     bits_ff [N];
   gcas_pkg::dot_type den_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic              v_src;
      logic [RMW-1:0]    rem_src, pre, test, rem_in;
      logic [W-1:0]      root_src, root_in;
      logic [SW-1:0]     bits_src;
      gcas_pkg::dot_type den_src;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign bits_src = sum_in;
         assign den_src  = den_in;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign bits_src = bits_ff[k-1];
         assign den_src  = den_ff[k-1];
      end

      always_comb begin
         pre  = {rem_src[RMW-3:0], bits_src[SW-1:SW-2]};
         test = {1'b0, root_src, 2'b01};
         if (pre >= test) begin
            rem_in  = pre - test;
            root_in = {root_src[W-2:0], 1'b1};
         end else begin
            rem_in  = pre;
            root_in = {root_src[W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            bits_ff[k] <= {bits_src[SW-3:0], 2'b00};
            den_ff[k]  <= den_src;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign root_out  = root_ff[N-1];
   assign den_out   = den_ff[N-1];
endmodule
`default_nettype wire

[src/gcas_vec.sv]
`default_nettype none
// Vectoring CORDIC: angle of (den, num), clamped to [0, pi].
module gcas_vec (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  gcas_pkg::dot_type           den_in,
   input  logic [gcas_pkg::ROOT_W-1:0] num_in,
   output logic                        out_valid,
   output logic [31:0]                 angle_out
);
   localparam int N = gcas_pkg::STEPS;

   logic p_valid_ff;
   gcas_pkg::vx_type p_x_ff, p_y_ff, p_x_in, p_y_in, num_ext;
   gcas_pkg::vz_type p_z_ff, p_z_in;

   logic             v_ff [N];
   gcas_pkg::vx_type x_ff [N];
   gcas_pkg::vx_type y_ff [N];
   gcas_pkg::vz_type z_ff [N];

   logic        o_valid_ff;
   logic [31:0] ang_ff, ang_in;

   // negative denominator: turn by -pi/2 first
   always_comb begin
      num_ext = gcas_pkg::vx_type'({1'b0, num_in});
      if (den_in[gcas_pkg::DOT_W-1]) begin
         p_x_in = num_ext;
         p_y_in = -gcas_pkg::vx_type'(den_in);
         p_z_in = gcas_pkg::vz_type'(gcas_pkg::HALF_PI_Q);
      end else begin
         p_x_in = gcas_pkg::vx_type'(den_in);
         p_y_in = num_ext;
         p_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_x_ff <= p_x_in;
         p_y_ff <= p_y_in;
         p_z_ff <= p_z_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic             v_src;
      gcas_pkg::vx_type x_src, y_src, dx, dy, x_in, y_in;
      gcas_pkg::vz_type z_src, z_in, step;

      if (i == 0) begin : g_first
         assign v_src = p_valid_ff;
         assign x_src = p_x_ff;
         assign y_src = p_y_ff;
         assign z_src = p_z_ff;
      end else begin : g_next
         assign v_src = v_ff[i-1];
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
      end

      assign dx   = y_src >>> i;
      assign dy   = x_src >>> i;
      assign step = gcas_pkg::vz_type'(gcas_pkg::atan_entry(5'(i)));

      always_comb begin
         if (y_src[gcas_pkg::VX_W-1]) begin
            x_in = x_src - dx;
            y_in = y_src + dy;
            z_in = z_src - step;
         end else if (y_src != '0) begin
            x_in = x_src + dx;
            y_in = y_src - dy;
            z_in = z_src + step;
         end else begin
            x_in = x_src;
            y_in = y_src;
            z_in = z_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   always_comb begin
      if (z_ff[N-1][gcas_pkg::VZ_W-1]) begin
         ang_in = '0;
      end else if (z_ff[N-1] > gcas_pkg::PI_Q) begin
         ang_in = 32'(gcas_pkg::PI_Q);
      end else begin
         ang_in = 32'(z_ff[N-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign angle_out = ang_ff;
endmodule
`default_nettype wire

[src/great_circle_angular_separation.sv]
// Throughput: one item per cycle while rsp is not stalled, set by the fully pipelined CORDIC, root and product stages.
// The whole pipeline advances together; it keeps moving while the held result waits
// as long as the last stage holds a bubble.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
`default_nettype none
module great_circle_angular_separation #(
   parameter int ANGLE_FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   gcas_req_if.sink    req,
   gcas_rsp_if.source  rsp
);
   localparam int SHIFT_UP = gcas_pkg::QB - ANGLE_FRAC_BITS;

   logic en, load;

   // input register, widened to Q30
   logic in_valid_ff;
   gcas_pkg::wide_ang_type d1_ff, d2_ff, da_ff, d1_in, d2_in, da_in;

   logic w_valid;
   gcas_pkg::ang_type w_d1, w_d2, w_da;

   logic sc_valid;
   gcas_pkg::trig_type sd1, cd1, sd2, cd2, sda, cda;

   logic m1_valid_ff, m2_valid_ff, m3_valid_ff, q1_valid_ff, q2_valid_ff;
   gcas_pkg::trig_type a1_ff, p1_ff, t1_ff, p3_ff, t3_ff, cda1_ff;
   gcas_pkg::trig_type a2_ff, p12_ff, p32_ff, t2_ff, t4_ff;
   gcas_pkg::trig_type a3_ff;
   gcas_pkg::dot_type  b3_ff, den3_ff, den4_ff, den5_ff;
   logic [gcas_pkg::TRIG_W-1:0] amag;
   logic [gcas_pkg::DOT_W-1:0]  bmag;
   logic [gcas_pkg::SQIN_W-1:0] asq_ff, bsq_ff, sum_ff;

   logic sq_valid;
   logic [gcas_pkg::ROOT_W-1:0] num;
   gcas_pkg::dot_type sq_den;

   logic vec_valid;
   logic [31:0] vec_angle;
   logic [32:0] rnd;

   logic        out_valid_ff;
   logic [29:0] sep_ff;

   assign load      = !out_valid_ff || rsp.ready;
   assign en        = load || !vec_valid;
   assign req.ready = en;

   always_comb begin
      d1_in = gcas_pkg::wide_ang_type'(req.dec_first) <<< SHIFT_UP;
      d2_in = gcas_pkg::wide_ang_type'(req.dec_second) <<< SHIFT_UP;
      da_in = (gcas_pkg::wide_ang_type'(signed'({1'b0, req.ra_second}))
             - gcas_pkg::wide_ang_type'(signed'({1'b0, req.ra_first}))) <<< SHIFT_UP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         da_ff <= da_in;
      end
   end

   gcas_wrap u_wrap_d1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(in_valid_ff),
      .ang_in(d1_ff), .out_valid(w_valid), .ang_out(w_d1)
   );
   gcas_wrap u_wrap_d2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(in_valid_ff),
      .ang_in(d2_ff), .out_valid(), .ang_out(w_d2)
   );
   gcas_wrap u_wrap_da (
      .clock(clock), .reset(reset), .en(en), .in_valid(in_valid_ff),
      .ang_in(da_ff), .out_valid(), .ang_out(w_da)
   );

   gcas_sincos u_sc_d1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(w_valid), .ang_in(w_d1),
      .out_valid(sc_valid), .sin_out(sd1), .cos_out(cd1)
   );
   gcas_sincos u_sc_d2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(w_valid), .ang_in(w_d2),
      .out_valid(), .sin_out(sd2), .cos_out(cd2)
   );
   gcas_sincos u_sc_da (
      .clock(clock), .reset(reset), .en(en), .in_valid(w_valid), .ang_in(w_da),
      .out_valid(), .sin_out(sda), .cos_out(cda)
   );

   always_comb begin
      amag = a3_ff[gcas_pkg::TRIG_W-1] ? gcas_pkg::TRIG_W'(-a3_ff)
                                      : gcas_pkg::TRIG_W'(a3_ff);
      bmag = b3_ff[gcas_pkg::DOT_W-1] ? gcas_pkg::DOT_W'(-b3_ff)
                                     : gcas_pkg::DOT_W'(b3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         q1_valid_ff <= 1'b0;
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= sc_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         q1_valid_ff <= m3_valid_ff;
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // first products
         a1_ff   <= gcas_pkg::qmul(cd2, sda);
         p1_ff   <= gcas_pkg::qmul(cd1, sd2);
         t1_ff   <= gcas_pkg::qmul(sd1, cd2);
         p3_ff   <= gcas_pkg::qmul(sd1, sd2);
         t3_ff   <= gcas_pkg::qmul(cd1, cd2);
         cda1_ff <= cda;
         // products with cos of the ra difference
         a2_ff   <= a1_ff;
         p12_ff  <= p1_ff;
         p32_ff  <= p3_ff;
         t2_ff   <= gcas_pkg::qmul(t1_ff, cda1_ff);
         t4_ff   <= gcas_pkg::qmul(t3_ff, cda1_ff);
         // numerator term b and the denominator
         a3_ff   <= a2_ff;
         b3_ff   <= gcas_pkg::dot_type'(p12_ff) - gcas_pkg::dot_type'(t2_ff);
         den3_ff <= gcas_pkg::dot_type'(p32_ff) + gcas_pkg::dot_type'(t4_ff);
         // squares, then their sum
         asq_ff  <= gcas_pkg::SQIN_W'(amag) * gcas_pkg::SQIN_W'(amag);
         bsq_ff  <= gcas_pkg::SQIN_W'(bmag) * gcas_pkg::SQIN_W'(bmag);
         den4_ff <= den3_ff;
         sum_ff  <= asq_ff + bsq_ff;
         den5_ff <= den4_ff;
      end
   end

   gcas_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(q2_valid_ff),
      .sum_in(sum_ff), .den_in(den5_ff),
      .out_valid(sq_valid), .root_out(num), .den_out(sq_den)
   );

   gcas_vec u_vec (
      .clock(clock), .reset(reset), .en(en), .in_valid(sq_valid),
      .den_in(sq_den), .num_in(num),
      .out_valid(vec_valid), .angle_out(vec_angle)
   );

   // round Q30 to the output format, ties up
   assign rnd = 33'(vec_angle) + (33'd1 << (SHIFT_UP - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= vec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sep_ff <= 30'(rnd >> SHIFT_UP);
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.separation = sep_ff;
endmodule
`default_nettype wire

[src/gcas_check.sv]
`default_nettype none
module gcas_check (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [29:0] separation
);
   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(separation))
      else $error("rsp item changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> separation <= 30'd843314857)
      else $error("separation beyond pi");

   // reset empties the pipeline; input side is open right after
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");
endmodule

bind great_circle_angular_separation gcas_check u_gcas_check (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .separation(rsp.separation)
);
`default_nettype wire

[tb/sv/great_circle_angular_separation_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module great_circle_angular_separation_tb;

   localparam int FRAC = 28;
   localparam int LATENCY = 107;
   localparam int N_RANDOM = 1300;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint Q_PI = 64'sd3373259426;
   localparam longint Q_HALF_PI = 64'sd1686629713;
   localparam longint Q_TWO_PI = 64'sd6746518852;
   localparam longint Q_INV_GAIN = 64'sd652032874;
   localparam logic [30:0] RA_MAX = 31'd1686629713;
   localparam logic signed [29:0] DEC_MAX = 30'sd421657428;
   localparam logic [29:0] SEP_PI = 30'd843314857;
   localparam logic [29:0] NO_SEP = 30'h3FFFFFFF;

   typedef struct packed {
      logic [30:0]        ra_first;
      logic signed [29:0] dec_first;
      logic [30:0]        ra_second;
      logic signed [29:0] dec_second;
      logic [29:0]        known_sep; // NO_SEP: use predictor
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   gcas_req_if req ();
   gcas_rsp_if rsp ();

   great_circle_angular_separation #(.ANGLE_FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   always #1 clock = ~clock;

   logic [29:0] sep_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit driving_done = 1'b0;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint qprod(longint a, longint b);
      return fshift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic longint atan_q(int i);
      return longint'(gcas_pkg::atan_entry(5'(i)));
   endfunction

   function automatic longint reduce_turn(longint v);
      longint r;
      r = v % Q_TWO_PI;
      if (r > Q_PI) r -= Q_TWO_PI;
      else if (r < -Q_PI) r += Q_TWO_PI;
      return r;
   endfunction

   task automatic rotate_trig(input longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = Q_INV_GAIN; y = 0; flip = 0;
      ang = reduce_turn(ang);
      if (ang > Q_HALF_PI) begin
         ang -= Q_PI; flip = 1;
      end else if (ang < -Q_HALF_PI) begin
         ang += Q_PI; flip = 1;
      end
      z = ang;
      for (int i = 0; i < 30; i++) begin
         dx = fshift(y, i); dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q(i);
         end else begin
            x += dx; y -= dy; z += atan_q(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = y; c = x;
   endtask

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b; res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint vector_phase(longint den, longint num);
      longint x, y, z, t, dx, dy;
      x = den; y = num; z = 0;
      if (x < 0) begin
         t = x; x = y; y = -t; z = Q_HALF_PI;
      end
      for (int i = 0; i < 30; i++) begin
         dx = fshift(y, i); dy = fshift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += atan_q(i);
         end else if (y < 0) begin
            x -= dx; y += dy; z -= atan_q(i);
         end
      end
      if (z < 0) z = 0;
      if (z > Q_PI) z = Q_PI;
      return z;
   endfunction

   task automatic predict_separation(input pair_row_type p, output logic [29:0] sep);
      longint scale, d1, d2, da, sd1, cd1, sd2, cd2, sda, cda, a, b, den, z;
      longint unsigned ua, ub, num;
      int down;
      down = 30 - FRAC;
      scale = 64'sd1 <<< down;
      d1 = longint'(p.dec_first) * scale;
      d2 = longint'(p.dec_second) * scale;
      da = (longint'({1'b0, p.ra_second}) - longint'({1'b0, p.ra_first})) * scale;
      rotate_trig(d1, sd1, cd1);
      rotate_trig(d2, sd2, cd2);
      rotate_trig(da, sda, cda);
      a = qprod(cd2, sda);
      b = qprod(cd1, sd2) - qprod(qprod(sd1, cd2), cda);
      den = qprod(sd1, sd2) + qprod(qprod(cd1, cd2), cda);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      num = floor_root(ua * ua + ub * ub);
      z = vector_phase(den, longint'(num));
      if (down > 0) z = (z + (64'sd1 <<< (down - 1))) >>> down;
      sep = z[29:0];
   endtask

   task automatic report_mismatch(input string what, input logic [29:0] got,
                                  input logic [29:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // directed rows; all checked against the predictor
   pair_row_type directed[14] = '{
      '{31'd0, 30'sd0, 31'd0, 30'sd0, NO_SEP},
      '{RA_MAX, DEC_MAX, RA_MAX, DEC_MAX, NO_SEP},
      '{31'd0, 30'sd0, RA_MAX, 30'sd0, NO_SEP},          // full turn on equator
      '{31'd0, DEC_MAX, 31'd0, -DEC_MAX, NO_SEP},
      '{31'd0, -DEC_MAX, RA_MAX, DEC_MAX, NO_SEP},       // antipodal
      '{RA_MAX, 30'sd0, 31'd0, 30'sd0, NO_SEP},
      '{31'd0, 30'sd0, 31'd421657428, 30'sd0, NO_SEP},   // quarter turn
      '{31'd0, 30'sd0, 31'h7FFFFFFF, 30'sd0, NO_SEP},    // ra diff wraps
      '{31'h7FFFFFFF, 30'sh1FFFFFFF, 31'd0, 30'sh20000000, NO_SEP},
      '{31'd5, 30'sh20000000, 31'd7, 30'sh1FFFFFFF, NO_SEP}, // dec beyond pole
      '{31'd100, 30'sd1, 31'd100, 30'sd0, NO_SEP},
      '{31'd0, 30'sd300000000, 31'd1200000000, -30'sd300000000, NO_SEP},
      '{31'd1, -30'sd1, 31'd0, 30'sd1, NO_SEP},
      '{31'd843314856, 30'sd0, 31'd0, 30'sd0, NO_SEP}
   };

   function automatic pair_row_type random_pair();
      pair_row_type p;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         p.ra_first = 31'($urandom_range(0, RA_MAX));
         p.ra_second = 31'($urandom_range(0, RA_MAX));
         p.dec_first = 30'($signed($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX);
         p.dec_second = 30'($signed($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX);
      end else if (mode < 9) begin
         p.ra_first = 31'($urandom); p.ra_second = 31'($urandom);
         p.dec_first = 30'($urandom); p.dec_second = 30'($urandom);
      end else begin
         // near-coincident or near-antipodal pairs
         p.ra_first = 31'($urandom_range(0, RA_MAX));
         p.dec_first = 30'($signed($urandom_range(0, 2 * DEC_MAX)) - DEC_MAX);
         if ($urandom_range(0, 1)) begin
            p.ra_second = 31'(p.ra_first + $urandom_range(0, 8));
            p.dec_second = 30'(p.dec_first + $signed($urandom_range(0, 8)) - 4);
         end else begin
            p.ra_second = 31'(p.ra_first + SEP_PI);
            p.dec_second = 30'(-p.dec_first + $signed($urandom_range(0, 8)) - 4);
         end
      end
      p.known_sep = NO_SEP;
      return p;
   endfunction

   task automatic send_pair(input pair_row_type p, input bit may_idle);
      logic [29:0] want;
      if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.ra_first <= p.ra_first;
      req.dec_first <= p.dec_first;
      req.ra_second <= p.ra_second;
      req.dec_second <= p.dec_second;
      predict_separation(p, want);
      if (p.known_sep != NO_SEP && want != p.known_sep)
         report_mismatch("predictor vs table", want, p.known_sep);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sep_queue.push_back(p.known_sep != NO_SEP ? p.known_sep : want);
      @(negedge clock);
   endtask

   initial begin
      req.valid = 1'b0;
      req.ra_first = '0; req.dec_first = '0; req.ra_second = '0; req.dec_second = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_pair(directed[i], 1'b1);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 200) quiet = 1'b1;
         send_pair(random_pair(), n % 150 > 40);
      end
      req.valid <= 1'b0;
      driving_done = 1'b1;
   end

   // receiver stalls in bursts
   initial begin
      int hold;
      hold = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet || reset) rsp.ready <= 1'b1;
         else if (hold > 0) begin
            hold--;
            rsp.ready <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 17) - 1;
            rsp.ready <= 1'b0;
         end else rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (sep_queue.size() == 0) report_mismatch("unexpected item", rsp.separation, '0);
         else begin
            logic [29:0] want;
            want = sep_queue.pop_front();
            if (rsp.separation !== want) report_mismatch("separation", rsp.separation, want);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      wait (driving_done);
      while (sep_queue.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
